@@ hw/rtl/rscs_pkg.sv @@
package rscs_pkg;

  localparam int unsigned FractionBitsDef  = 30;
  localparam int unsigned PairCountBitsDef = 16;

  localparam int unsigned DistW  = 24;
  localparam int unsigned ExpNW  = 6;
  localparam int unsigned ExpMW  = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned ValueW = 31;
  localparam int unsigned SumW   = 47;
  localparam int unsigned OutDataW = 80;

  localparam logic [DistW-1:0] CutoffReset = 24'd1048576;
  localparam logic [ExpNW-1:0] ExpNReset   = 6'd2;
  localparam logic [ExpMW-1:0] ExpMReset   = 7'd24;

  localparam logic [CfgIdxW-1:0] RegCutoff = 2'd0;
  localparam logic [CfgIdxW-1:0] RegExpN   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegExpM   = 2'd2;

  typedef struct packed {
    logic done;
    logic sat;
  } div_stat_t;

endpackage

@@ hw/rtl/rscs_mul.sv @@
module rscs_mul import rscs_pkg::*; #(
  parameter int unsigned W = FractionBitsDef + 1
) (
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [2*W-1:0] p_o
);

  assign p_o = (2*W)'(a_i) * (2*W)'(b_i);

endmodule

@@ hw/rtl/rscs_div.sv @@
module rscs_div import rscs_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FractionBitsDef,
  parameter int unsigned NW = 2 * FRACTION_BITS + 1,
  parameter int unsigned DW = FRACTION_BITS + 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [NW-1:0]            num_i,
  input  logic [DW-1:0]            den_i,
  output div_stat_t                stat_o,
  output logic [FRACTION_BITS:0]   quot_o
);

  localparam int unsigned VW = FRACTION_BITS + 1;
  localparam int unsigned CW = $clog2(VW + 1);

  logic          busy_q, chk_q, done_q, sat_q;
  logic [NW-1:0] num_q;
  logic [DW-1:0] den_q, rem_q;
  logic [VW-1:0] low_q, quot_q;
  logic [CW-1:0] cnt_q;
  logic [DW:0]   r2;
  logic          ge;

  assign r2 = {rem_q, low_q[VW-1]};
  assign ge = r2 >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      chk_q  <= 1'b0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        chk_q  <= 1'b1;
      end else if (chk_q) begin
        chk_q <= 1'b0;
        if ((num_q >> VW) >= NW'(den_q)) begin
          sat_q  <= 1'b1;
          done_q <= 1'b1;
          busy_q <= 1'b0;
        end else begin
          sat_q <= 1'b0;
        end
      end else if (busy_q && cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
    end else if (chk_q) begin
      rem_q  <= DW'(num_q >> VW);
      low_q  <= num_q[VW-1:0];
      cnt_q  <= CW'(VW);
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? DW'(r2 - {1'b0, den_q}) : DW'(r2);
      low_q  <= {low_q[VW-2:0], 1'b0};
      quot_q <= {quot_q[VW-2:0], ge};
      cnt_q  <= cnt_q - CW'(1);
    end
  end

  assign stat_o = '{done: done_q, sat: sat_q};
  assign quot_o = quot_q;

endmodule

@@ hw/rtl/rational_switch_contact_sum.sv @@
// Rational switching function contact sum. Each beat on s_axis carries one pair
// distance (Q4.20); the block forms r = d/cutoff, evaluates (1-r^n)/(1-r^m)
// (or 1/(1+r^n) when 2n = m) in Q1.30 with truncation, saturates at 1.0, and
// adds it to a running sum that is returned with every result and cleared after
// the beat marked tlast. One item at a time: the ratio and the final quotient each
// take a pass through the shared restoring divider, and the powers, up to three,
// are formed by square-and-multiply on the shared multiplier. A distance equal
// to the cutoff (with 2n != m) skips the ratio and the powers, and exponents with
// n >= m (and 2n != m) skip the divider and give 1.0. The output state waits
// while the output register is stalled.
// s_axis_tready is low while an item is in work. Write cfg_* only when idle.
module rational_switch_contact_sum import rscs_pkg::*; #(
  parameter int unsigned FRACTION_BITS   = FractionBitsDef,
  parameter int unsigned PAIR_COUNT_BITS = PairCountBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [DistW-1:0]    s_axis_tdata,  // pair_distance
  input  logic                s_axis_tlast,  // last_pair
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // pair_value, running_sum, zero pad
  output logic                m_axis_tlast   // sum_done
);

  localparam int unsigned F     = FRACTION_BITS;
  localparam int unsigned VW    = F + 1;
  localparam int unsigned NW    = F + ((F + 1) > DistW ? (F + 1) : DistW);
  localparam int unsigned DW    = (F + 2) > DistW ? (F + 2) : DistW;
  localparam int unsigned ACC_W = F + PAIR_COUNT_BITS + 1;
  localparam logic [VW-1:0]    ONE     = VW'(1) << F;
  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RATIO = 3'd1;
  localparam logic [2:0] S_POW   = 3'd2;
  localparam logic [2:0] S_MULA  = 3'd3;
  localparam logic [2:0] S_FDIV  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam logic [1:0] JOB_N  = 2'd0;
  localparam logic [1:0] JOB_M  = 2'd1;
  localparam logic [1:0] JOB_MN = 2'd2;

  logic [DistW-1:0] cut_q;
  logic [ExpNW-1:0] n_q;
  logic [ExpMW-1:0] m_q;

  logic [2:0] state_q, state_d;
  logic [1:0] job_q, job_d;
  logic       ph_q, ph_d, half_q, half_d, above_q, above_d, last_q, last_d;
  logic [ExpMW-1:0] exp_q, exp_d;
  logic [VW-1:0] q_q, q_d, base_q, base_d, pacc_q, pacc_d, pn_q, pn_d, pm_q, pm_d;
  logic [VW-1:0] f_q, f_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [VW-1:0] ov_q, ov_d;
  logic [ACC_W-1:0] os_q, os_d;
  logic ol_q, ol_d, ovld_q, ovld_d;

  logic [DistW-1:0] c, lo, hi;
  logic             accept, half, nge;
  logic [VW-1:0]    mul_a, mul_b, qm, a_val;
  logic [2*VW-1:0]  mul_p;
  logic             div_start;
  logic [NW-1:0]    div_num;
  logic [DW-1:0]    div_den, b_den;
  div_stat_t        div_stat;
  logic [VW-1:0]    div_quot;
  logic [ACC_W:0]   sum;

  rscs_mul #(.W(VW)) u_mul (.a_i(mul_a), .b_i(mul_b), .p_o(mul_p));

  rscs_div #(.FRACTION_BITS(F), .NW(NW), .DW(DW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .stat_o(div_stat), .quot_o(div_quot)
  );

  assign accept = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign c      = (cut_q == '0) ? DistW'(1) : cut_q;
  assign lo     = (s_axis_tdata < c) ? s_axis_tdata : c;
  assign hi     = (s_axis_tdata < c) ? c : s_axis_tdata;
  assign half   = ({n_q, 1'b0} == m_q);
  assign nge    = ({1'b0, n_q} >= m_q);

  assign a_val = ONE - pn_q;
  assign b_den = (pm_q == ONE) ? DW'(1) : DW'(ONE - pm_q);
  assign mul_a = (state_q == S_POW && ph_q) ? base_q : pacc_q;
  assign mul_b = (state_q == S_MULA) ? a_val : base_q;
  assign qm    = VW'(mul_p >> F);
  assign sum   = {1'b0, acc_q} + (ACC_W + 1)'(f_q);

  always_comb begin
    state_d = state_q; job_d = job_q; ph_d = ph_q; half_d = half_q;
    above_d = above_q; last_d = last_q; exp_d = exp_q; q_d = q_q;
    base_d = base_q; pacc_d = pacc_q; pn_d = pn_q; pm_d = pm_q; f_d = f_q;
    acc_d = acc_q; ov_d = ov_q; os_d = os_q; ol_d = ol_q;
    ovld_d = ovld_q & ~m_axis_tready;
    div_start = 1'b0; div_num = '0; div_den = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          last_d  = s_axis_tlast;
          above_d = s_axis_tdata > c;
          half_d  = half;
          if (!half && nge) begin
            f_d = ONE;
            state_d = S_OUT;
          end else if (!half && s_axis_tdata == c) begin
            div_start = 1'b1;
            div_num = NW'(n_q) << F;
            div_den = DW'(m_q);
            state_d = S_FDIV;
          end else begin
            div_start = 1'b1;
            div_num = NW'(lo) << F;
            div_den = DW'(hi);
            state_d = S_RATIO;
          end
        end
      end
      S_RATIO: begin
        if (div_stat.done) begin
          q_d = div_quot; base_d = div_quot; pacc_d = ONE;
          exp_d = ExpMW'(n_q); ph_d = 1'b0; job_d = JOB_N;
          state_d = S_POW;
        end
      end
      S_POW: begin
        if (exp_q == '0) begin
          unique case (job_q)
            JOB_N: begin
              pn_d = pacc_q;
              if (half_q) begin
                div_start = 1'b1;
                div_num = NW'(above_q ? pacc_q : ONE) << F;
                div_den = DW'({1'b0, pacc_q} + {1'b0, ONE});
                state_d = S_FDIV;
              end else begin
                job_d = JOB_M; base_d = q_q; pacc_d = ONE; exp_d = m_q;
              end
            end
            JOB_M: begin
              pm_d = pacc_q;
              if (above_q) begin
                job_d = JOB_MN; base_d = q_q; pacc_d = ONE;
                exp_d = m_q - ExpMW'(n_q);
              end else begin
                div_start = 1'b1;
                div_num = NW'(a_val) << F;
                div_den = (pacc_q == ONE) ? DW'(1) : DW'(ONE - pacc_q);
                state_d = S_FDIV;
              end
            end
            default: state_d = S_MULA;
          endcase
        end else if (!ph_q) begin
          if (exp_q[0]) pacc_d = qm;
          ph_d = 1'b1;
        end else begin
          base_d = qm;
          exp_d = exp_q >> 1;
          ph_d = 1'b0;
        end
      end
      S_MULA: begin
        div_start = 1'b1;
        div_num = NW'(mul_p);
        div_den = b_den;
        state_d = S_FDIV;
      end
      S_FDIV: begin
        if (div_stat.done) begin
          f_d = (div_stat.sat || div_quot > ONE) ? ONE : div_quot;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ovld_q || m_axis_tready) begin
          os_d = (sum > (ACC_W + 1)'(ACC_MAX)) ? ACC_MAX : ACC_W'(sum);
          ov_d = f_q;
          ol_d = last_q;
          ovld_d = 1'b1;
          acc_d = last_q ? '0 : os_d;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_q <= CutoffReset;
      n_q <= ExpNReset;
      m_q <= ExpMReset;
      state_q <= S_IDLE;
      acc_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegCutoff: cut_q <= cfg_data_i[DistW-1:0];
          RegExpN:   n_q <= cfg_data_i[ExpNW-1:0];
          RegExpM:   m_q <= cfg_data_i[ExpMW-1:0];
          default: ;
        endcase
      end
      state_q <= state_d;
      acc_q <= acc_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d; ph_q <= ph_d; half_q <= half_d; above_q <= above_d;
    last_q <= last_d; exp_q <= exp_d; q_q <= q_d; base_q <= base_d;
    pacc_q <= pacc_d; pn_q <= pn_d; pm_q <= pm_d; f_q <= f_d;
    ov_q <= ov_d; os_q <= os_d; ol_q <= ol_d;
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tlast  = ol_q;
  assign m_axis_tdata  = {(OutDataW - ValueW - SumW)'(0), SumW'(os_q), ValueW'(ov_q)};

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_RATIO || state_q == S_FDIV))
    else $error("divider finished outside a wait state");

  a_value_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q |-> (ov_q <= ONE))
    else $error("pair value above 1.0");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("ready right after an accepted beat");

endmodule

@@ tb/rational_switch_contact_sum_checker.sv @@
module rational_switch_contact_sum_checker import rscs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [DistW-1:0]    s_axis_tdata,
  input  logic                s_axis_tlast,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                m_axis_tlast,
  output int unsigned         err_cnt_o,
  output int unsigned         pending_o
);

  localparam int unsigned Frac = FractionBitsDef;
  localparam logic [63:0] OneQ = 64'd1 << Frac;
  localparam logic [63:0] AccMax = (64'd1 << (Frac + PairCountBitsDef + 1)) - 64'd1;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [SumW-1:0]   total;
    logic              done;
  } contact_t;

  contact_t          expected_q[$];
  logic [DistW-1:0]  cutoff;
  logic [ExpNW-1:0]  exp_n;
  logic [ExpMW-1:0]  exp_m;
  logic [63:0]       contact_acc;

  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
    return (a * b) >> Frac;
  endfunction

  function automatic logic [63:0] fx_pow(logic [63:0] base, logic [63:0] e);
    logic [63:0] acc;
    acc = OneQ;
    while (e != 0) begin
      if (e[0]) acc = fx_mul(acc, base);
      e = e >> 1;
      base = fx_mul(base, base);
    end
    return acc;
  endfunction

  function automatic logic [63:0] switching_value(logic [63:0] d, logic [63:0] c,
                                                  logic [63:0] n, logic [63:0] m);
    logic [63:0] lo, hi, q, p, a, b, f;
    lo = (d < c) ? d : c;
    hi = (d < c) ? c : d;
    q = (lo << Frac) / hi;
    if (2 * n == m) begin
      p = fx_pow(q, n);
      f = (d > c) ? (p << Frac) / (OneQ + p) : (OneQ << Frac) / (OneQ + p);
    end else if (n >= m) begin
      f = OneQ;
    end else if (d == c) begin
      f = (n << Frac) / m;
    end else begin
      a = OneQ - fx_pow(q, n);
      b = OneQ - fx_pow(q, m);
      if (b == 0) b = 1;
      f = (d > c) ? (fx_pow(q, m - n) * a) / b : (a << Frac) / b;
    end
    if (f > OneQ) f = OneQ;
    return f;
  endfunction

  assign pending_o = expected_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [63:0] c, f, s;
    contact_t got, want;
    int unsigned errs;
    if (!rst_ni) begin
      cutoff <= CutoffReset;
      exp_n <= ExpNReset;
      exp_m <= ExpMReset;
      contact_acc = 0;
      err_cnt_o <= 0;
      expected_q.delete();
    end else begin
      errs = err_cnt_o;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegCutoff: cutoff <= cfg_data_i;
          RegExpN: exp_n <= cfg_data_i[ExpNW-1:0];
          RegExpM: exp_m <= cfg_data_i[ExpMW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        c = (cutoff != 0) ? 64'(cutoff) : 64'd1;
        f = switching_value(64'(s_axis_tdata), c, 64'(exp_n), 64'(exp_m));
        s = contact_acc + f;
        if (s > AccMax) s = AccMax;
        want.value = f[ValueW-1:0];
        want.total = s[SumW-1:0];
        want.done = s_axis_tlast;
        expected_q.insert(expected_q.size(), want);
        contact_acc = s_axis_tlast ? 64'd0 : s;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.value = m_axis_tdata[ValueW-1:0];
        got.total = m_axis_tdata[ValueW +: SumW];
        got.done = m_axis_tlast;
        if (expected_q.size() == 0) begin
          $error("unexpected result beat");
          errs = errs + 1;
        end else begin
          want = expected_q.pop_front();
          if (got.value !== want.value) begin
            $error("pair_value: expected %0d, actual %0d", want.value, got.value);
            errs = errs + 1;
          end
          if (got.total !== want.total) begin
            $error("running_sum: expected %0d, actual %0d", want.total, got.total);
            errs = errs + 1;
          end
          if (got.done !== want.done) begin
            $error("sum_done: expected %0d, actual %0d", want.done, got.done);
            errs = errs + 1;
          end
        end
      end
      err_cnt_o <= errs;
    end
  end

endmodule

@@ tb/rational_switch_contact_sum_tb.sv @@
module rational_switch_contact_sum_tb import rscs_pkg::*;;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = RegCutoff;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DistW-1:0]    s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  int unsigned         err_cnt;
  int unsigned         pending;
  int unsigned         cycle_cnt = 0;
  logic                hold_off = 1'b0;
  logic                calm = 1'b0;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  rational_switch_contact_sum i_dut (.*);

  rational_switch_contact_sum_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .err_cnt_o(err_cnt), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !hold_off && (calm || $urandom_range(99) >= 12);
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [DistW-1:0] c, logic [ExpNW-1:0] n, logic [ExpMW-1:0] m);
    write_reg(RegCutoff, c);
    write_reg(RegExpN, CfgDataW'(n));
    write_reg(RegExpM, CfgDataW'(m));
    write_reg(RegUnused, CfgDataW'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_pair(logic [DistW-1:0] d, logic last);
    while (!calm && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  function automatic logic [DistW-1:0] near_cutoff(logic [DistW-1:0] c);
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 4) return DistW'($urandom_range(32'(c) * 2 > 32'hFFFFFF ? 32'hFFFFFF : 32'(c) * 2));
    if (pick < 6) return c + DistW'($urandom_range(4)) - DistW'(2);
    if (pick < 8) return DistW'($urandom);
    return (pick == 8) ? DistW'(0) : c;
  endfunction

  initial begin
    logic [DistW-1:0] c;
    logic [ExpNW-1:0] n;
    logic [ExpMW-1:0] m;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pair(24'd0, 1'b0);
    send_pair(24'hFFFFFF, 1'b0);
    send_pair(24'd1048576, 1'b0);
    send_pair(24'd524288, 1'b0);
    send_pair(24'd2097152, 1'b1);
    drain();
    set_config(24'd1048576, 6'd6, 7'd12);
    send_pair(24'd1048576, 1'b0);
    send_pair(24'd1572864, 1'b0);
    send_pair(24'd262144, 1'b1);
    drain();
    set_config(24'd0, 6'd0, 7'd0);
    send_pair(24'd0, 1'b0);
    send_pair(24'd1, 1'b0);
    send_pair(24'd5, 1'b1);
    drain();
    set_config(24'hFFFFFF, 6'd0, 7'd64);
    send_pair(24'd100, 1'b0);
    send_pair(24'hFFFFFF, 1'b1);
    drain();
    set_config(24'd2000000, 6'd32, 7'd8);
    send_pair(24'd1000000, 1'b0);
    send_pair(24'd3000000, 1'b1);
    drain();
    set_config(24'd1048576, 6'd63, 7'd127);
    send_pair(24'd1000000, 1'b0);
    send_pair(24'd1100000, 1'b1);
    drain();
    set_config(24'd300000, 6'd1, 7'd64);
    send_pair(24'd299999, 1'b0);
    send_pair(24'd300001, 1'b1);
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin c = 24'hFFFFFF; n = 6'd32; m = 7'd64; end
        1: begin c = 24'd1; n = 6'd1; m = 7'd2; end
        2: begin c = 24'd1048576; n = 6'd6; m = 7'd12; end
        default: begin
          c = DistW'($urandom_range(1, 24'hFFFFFF));
          n = ExpNW'($urandom_range(1, 32));
          m = ExpMW'($urandom_range(n + 1, 64));
          if ($urandom_range(9) == 0) m = ExpMW'($urandom);
        end
      endcase
      set_config(c, n, m);
      calm <= (phase == 4);
      if (phase == 6) begin
        fork
          begin
            hold_off <= 1'b1;
            repeat (600) @(posedge clk_i);
            hold_off <= 1'b0;
          end
          for (int k = 0; k < 20; k++) send_pair(near_cutoff(c), $urandom_range(7) == 0);
        join
      end
      for (int k = 0; k < 150; k++) begin
        send_pair(near_cutoff(c), $urandom_range(11) == 0);
        if (k == 75 && phase == 3) begin
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
      end
      send_pair(near_cutoff(c), 1'b1);
      drain();
    end
    calm <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
